### rtl/fifo_frame_allocator_assert.svh
// Assertion macros for the FIFO frame allocator.
// Used by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef FIFO_FRAME_ALLOCATOR_ASSERT_SVH
`define FIFO_FRAME_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define FFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ffa assertion failed");

`define FFA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ffa reset assertion failed");

`else

`define FFA_ASSERT(lbl, prop)

`define FFA_ASSERT_RST(lbl, prop)

`endif

`endif

### rtl/ffa_pkg.sv
// Shared types and constants for the FIFO frame allocator.
// No dependencies.
`default_nettype none

package ffa_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int PAGE_W         = 20;
    localparam int THREAD_W       = 6;
    localparam int FRAME_OUT_W    = 6;
    localparam int CFG_W          = 7;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_COUNT = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic pop;
        logic push;
    } t_queue_cmd;

endpackage

`default_nettype wire

### rtl/ffa_cell.sv
// One queue cell: holds one occupant entry, loads new data or takes its neighbor's.
// Depends on ffa_pkg.
`default_nettype none

module ffa_cell #(
    parameter int WIDTH = 1
) (
    input  wire logic                i_clk,
    input  wire ffa_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [WIDTH-1:0]    i_load_data,
    input  wire logic [WIDTH-1:0]    i_next_data,
    output logic      [WIDTH-1:0]    o_data
);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_load_data;
        end else if (i_ctrl.shift) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/ffa_queue.sv
// Occupant queue built as a row of ffa_cell; the oldest entry sits in cell 0.
// Depends on ffa_pkg and ffa_cell.
`default_nettype none

module ffa_queue #(
    parameter  int DEPTH = 1,
    parameter  int WIDTH = 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ffa_pkg::t_queue_cmd i_cmd,
    input  wire logic [WIDTH-1:0]    i_data,
    output logic      [WIDTH-1:0]    o_head,
    output logic      [CNT_W-1:0]    o_fill
);

    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic [CNT_W-1:0]    w_wpos;
    logic [WIDTH-1:0]    w_cell_q [DEPTH];
    logic [WIDTH-1:0]    w_next   [DEPTH];
    ffa_pkg::t_cell_ctrl w_ctrl   [DEPTH];

    // on a pop everything moves one cell toward the head first
    assign w_wpos = i_cmd.pop ? (r_fill - CNT_W'(1)) : r_fill;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = w_cell_q[g];
        end else begin : g_mid
            assign w_next[g] = w_cell_q[g+1];
        end

        assign w_ctrl[g].shift = i_cmd.pop;
        assign w_ctrl[g].load  = i_cmd.push && (w_wpos == CNT_W'(g));

        ffa_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl[g]),
            .i_load_data (i_data),
            .i_next_data (w_next[g]),
            .o_data      (w_cell_q[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.push && !i_cmd.pop) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_head = w_cell_q[0];
    assign o_fill = r_fill;

endmodule

`default_nettype wire

### rtl/fifo_frame_allocator.sv
// FIFO frame allocator top level: control, configuration port, output register.
// Depends on ffa_pkg, ffa_queue and fifo_frame_allocator_assert.svh.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_stall   i_page_number, i_thread_id
//   out      from block o_out_valid / i_out_stall o_frame, o_evicted,
//                                                 o_evicted_page, o_evicted_thread
//   cfg      to block   APB psel/penable/pready   frame_count at address 0
//
// Per request: the accepting edge captures the request, then the work state does the
// queue read-modify-write and loads the output register; a new request is taken only
// back in the idle state. Frames are handed out in ascending order, so the queue fill
// count is also the next free frame. Reset (synchronous) empties the queue. A held
// result stalls the work state of the next request until it is taken.
`default_nettype none

`include "fifo_frame_allocator_assert.svh"

module fifo_frame_allocator #(
    parameter int MAX_FRAMES = ffa_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [ffa_pkg::PAGE_W-1:0]         i_page_number,
    input  wire logic [ffa_pkg::THREAD_W-1:0]       i_thread_id,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [ffa_pkg::FRAME_OUT_W-1:0]    o_frame,
    output logic                                    o_evicted,
    output logic      [ffa_pkg::PAGE_W-1:0]         o_evicted_page,
    output logic      [ffa_pkg::THREAD_W-1:0]       o_evicted_thread,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ffa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [ffa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [ffa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int ENTRY_W = FRAME_W + ffa_pkg::PAGE_W + ffa_pkg::THREAD_W;
    localparam int LIM_W   = (CNT_W > ffa_pkg::CFG_W) ? CNT_W : ffa_pkg::CFG_W;

    ffa_pkg::t_state                  r_state;
    ffa_pkg::t_state                  n_state;
    logic [ffa_pkg::PAGE_W-1:0]       r_page;
    logic [ffa_pkg::THREAD_W-1:0]     r_thread;
    logic [ffa_pkg::CFG_W-1:0]        r_frame_count;

    logic                             r_out_valid;
    logic [ffa_pkg::FRAME_OUT_W-1:0]  r_frame;
    logic                             r_evicted;
    logic [ffa_pkg::PAGE_W-1:0]       r_ev_page;
    logic [ffa_pkg::THREAD_W-1:0]     r_ev_thread;

    logic                             w_in_acc;
    logic                             w_out_free;
    logic                             w_work;
    logic                             w_found;
    logic                             w_cfg_wr;
    logic                             w_reg_idx;
    logic [LIM_W-1:0]                 w_cfg;
    logic [LIM_W-1:0]                 w_limit;
    logic [CNT_W-1:0]                 w_fill;
    logic [ENTRY_W-1:0]               w_head;
    logic [ENTRY_W-1:0]               w_entry;
    logic [FRAME_W-1:0]               w_head_frame;
    logic [FRAME_W-1:0]               w_new_frame;
    ffa_pkg::t_queue_cmd              w_cmd;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (w_reg_idx == ffa_pkg::REG_FRAME_COUNT && paddr[1:0] == 2'b00) begin
            prdata = ffa_pkg::APB_DATA_W'(r_frame_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= ffa_pkg::FRAME_COUNT_RST;
        end else if (w_cfg_wr && w_reg_idx == ffa_pkg::REG_FRAME_COUNT) begin
            r_frame_count <= pwdata[ffa_pkg::CFG_W-1:0];
        end
    end

    // zero counts as one, above the built size saturates
    assign w_cfg = LIM_W'(r_frame_count);

    always_comb begin
        w_limit = w_cfg;
        if (w_cfg == '0) begin
            w_limit = LIM_W'(1);
        end else if (w_cfg > LIM_W'(MAX_FRAMES)) begin
            w_limit = LIM_W'(MAX_FRAMES);
        end
    end

    // ---------------- control ----------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        w_work     = 1'b0;
        case (r_state)
            ffa_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = ffa_pkg::ST_WORK;
                end
            end
            ffa_pkg::ST_WORK: begin
                if (w_out_free) begin
                    w_work  = 1'b1;
                    n_state = ffa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_page   <= i_page_number;
            r_thread <= i_thread_id;
        end
    end

    // ---------------- queue ----------------
    assign w_found      = LIM_W'(w_fill) < w_limit;
    assign w_head_frame = w_head[ENTRY_W-1 -: FRAME_W];
    assign w_new_frame  = w_found ? FRAME_W'(w_fill) : w_head_frame;
    assign w_entry      = {w_new_frame, r_page, r_thread};
    assign w_cmd.pop    = w_work && !w_found;
    assign w_cmd.push   = w_work;

    ffa_queue #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_data  (w_entry),
        .o_head  (w_head),
        .o_fill  (w_fill)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_work) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_work) begin
            r_frame   <= ffa_pkg::FRAME_OUT_W'(w_new_frame);
            r_evicted <= !w_found;
            if (w_found) begin
                r_ev_page   <= '0;
                r_ev_thread <= '0;
            end else begin
                r_ev_page   <= w_head[ffa_pkg::THREAD_W +: ffa_pkg::PAGE_W];
                r_ev_thread <= w_head[ffa_pkg::THREAD_W-1:0];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame          = r_frame;
    assign o_evicted        = r_evicted;
    assign o_evicted_page   = r_ev_page;
    assign o_evicted_thread = r_ev_thread;

    // ---------------- assertions ----------------
    `FFA_ASSERT(a_fill_bound, w_fill <= CNT_W'(MAX_FRAMES))
    `FFA_ASSERT(a_evict_nonempty, w_cmd.pop |-> (w_fill != '0))
    `FFA_ASSERT(a_result_from_work, $rose(r_out_valid) |-> $past(r_state == ffa_pkg::ST_WORK))
    `FFA_ASSERT_RST(a_reset_empty, !i_rst_n |=> (w_fill == '0 && !r_out_valid))

endmodule

`default_nettype wire

### sim/fifo_frame_allocator_test.sv
`timescale 1ns / 1ps
// Testbench for fifo_frame_allocator: directed table, then random phases under
// several frame counts, checked against an in-bench FIFO replacement predictor.
// Depends on ffa_pkg and the fifo_frame_allocator RTL.
module fifo_frame_allocator_test;

    localparam int APB_ADDR_W     = ffa_pkg::APB_ADDR_W;
    localparam int APB_DATA_W     = ffa_pkg::APB_DATA_W;
    localparam int PAGE_W         = ffa_pkg::PAGE_W;
    localparam int THREAD_W       = ffa_pkg::THREAD_W;
    localparam int FRAME_OUT_W    = ffa_pkg::FRAME_OUT_W;
    localparam int CFG_W          = ffa_pkg::CFG_W;
    localparam int MAX_FRAMES_DEF = ffa_pkg::MAX_FRAMES_DEF;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = ffa_pkg::FRAME_COUNT_RST;
    localparam logic             REG_FRAME_COUNT = ffa_pkg::REG_FRAME_COUNT;

    localparam int NUM_PHASES     = 11;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_COUNT = {REG_FRAME_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_NO_REG      = {~REG_FRAME_COUNT, 2'b00};

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic                   evicted;
        logic [PAGE_W-1:0]      page;
        logic [THREAD_W-1:0]    thread;
    } t_grant;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic [PAGE_W-1:0]      page;
        logic [THREAD_W-1:0]    thread;
    } t_occupant;

    typedef enum {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [APB_ADDR_W-1:0] addr;
        logic [31:0]           data;   // page for requests, register value for config
        logic [THREAD_W-1:0]   thread;
        bit                    typed;
        t_grant                want;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [PAGE_W-1:0]        i_page_number;
    logic [THREAD_W-1:0]      i_thread_id;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [FRAME_OUT_W-1:0]   o_frame;
    logic                     o_evicted;
    logic [PAGE_W-1:0]        o_evicted_page;
    logic [THREAD_W-1:0]      o_evicted_thread;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    // predictor state
    logic [MAX_FRAMES_DEF-1:0] free_map = '1;
    t_occupant                 resident_q[$];
    logic [CFG_W-1:0]          frame_count_reg = FRAME_COUNT_RST;

    t_grant      grant_q[$];
    int unsigned mismatch_count = 0;

    // pacing
    int unsigned tx_gap_pct  = 0;
    int unsigned rx_idle_pct = 0;
    bit          quiet       = 1'b0;
    bit          long_hold   = 1'b0;
    int unsigned rx_burst    = 0;
    bit          stall_next;
    t_grant      want_grant;

    t_stim_row   stim_table[$];
    int          phase_frames[NUM_PHASES] = '{64, 1, 0, 127, 2, 64, 33, 80, -1, -1, 64};

    fifo_frame_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_page_number    (i_page_number),
        .i_thread_id      (i_thread_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame          (o_frame),
        .o_evicted        (o_evicted),
        .o_evicted_page   (o_evicted_page),
        .o_evicted_thread (o_evicted_thread),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    // lowest free frame below the active count, else evict the oldest occupant
    function automatic t_grant allocate_frame(input logic [PAGE_W-1:0] page,
                                              input logic [THREAD_W-1:0] thread);
        int        limit;
        bit        found;
        t_grant    g;
        t_occupant oldest;
        t_occupant fresh;
        limit = int'(frame_count_reg);
        if (limit == 0)
            limit = 1;
        if (limit > MAX_FRAMES_DEF)
            limit = MAX_FRAMES_DEF;
        g = '0;
        found = 1'b0;
        for (int i = 0; i < limit && !found; i++) begin
            if (free_map[i]) begin
                free_map[i] = 1'b0;
                g.frame = FRAME_OUT_W'(i);
                found = 1'b1;
            end
        end
        if (!found && resident_q.size() > 0) begin
            oldest = resident_q.pop_front();
            g.frame = oldest.frame;
            g.evicted = 1'b1;
            g.page = oldest.page;
            g.thread = oldest.thread;
        end
        if (resident_q.size() < MAX_FRAMES_DEF) begin
            fresh.frame = g.frame;
            fresh.page = page;
            fresh.thread = thread;
            resident_q.push_back(fresh);
        end
        return g;
    endfunction

    function automatic t_stim_row req_row(input logic [PAGE_W-1:0] page,
                                          input logic [THREAD_W-1:0] thread,
                                          input bit typed, input t_grant want);
        t_stim_row r;
        r.kind = ROW_REQUEST;
        r.addr = '0;
        r.data = 32'(page);
        r.thread = thread;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [APB_ADDR_W-1:0] addr,
                                          input logic [31:0] data);
        t_stim_row r;
        r.kind = ROW_CONFIG;
        r.addr = addr;
        r.data = data;
        r.thread = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input int unsigned bits);
        logic [31:0] mask;
        mask = (32'd1 << bits) - 32'd1;
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return mask;
            default: return $urandom() & mask;
        endcase
    endfunction

    task automatic send_request(input logic [PAGE_W-1:0] page,
                                input logic [THREAD_W-1:0] thread,
                                input bit typed, input t_grant want);
        t_grant g;
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        i_thread_id   <= thread;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = allocate_frame(page, thread);
        grant_q.push_back(typed ? want : g);
    endtask

    task automatic read_register(input logic [APB_ADDR_W-1:0] addr,
                                 input logic [CFG_W-1:0] want);
        logic [APB_DATA_W-1:0] value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (value[CFG_W-1:0] !== want)
            note_mismatch($sformatf("frame_count readback: expected %0d, got %0d",
                                    want, value[CFG_W-1:0]));
    endtask

    // only called with nothing in flight
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [31:0] data);
        i_in_valid <= 1'b0;
        while (grant_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_FRAME_COUNT)
            frame_count_reg = data[CFG_W-1:0];
        @(posedge i_clk);
        read_register(ADDR_FRAME_COUNT, frame_count_reg);
    endtask

    // result side: check accepted transactions, drive stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (grant_q.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction, frame %0d", o_frame));
            end else begin
                want_grant = grant_q.pop_front();
                if (o_frame !== want_grant.frame || o_evicted !== want_grant.evicted ||
                    o_evicted_page !== want_grant.page ||
                    o_evicted_thread !== want_grant.thread)
                    note_mismatch($sformatf(
                        "expected frame %0d evict %0b page %05h thread %0d, got %0d %0b %05h %0d",
                        want_grant.frame, want_grant.evicted, want_grant.page,
                        want_grant.thread, o_frame, o_evicted, o_evicted_page,
                        o_evicted_thread));
            end
        end
        if (quiet) begin
            stall_next = 1'b0;
            rx_burst = 0;
        end else if (long_hold) begin
            stall_next = 1'b1;
        end else if (rx_burst > 0) begin
            stall_next = 1'b1;
            rx_burst--;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            stall_next = 1'b1;
            rx_burst = $urandom_range(0, 8);
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          frames;
        int unsigned n_items;
        int unsigned pct_choice[3];
        pct_choice    = '{0, 20, 50};
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_page_number = '0;
        i_thread_id   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // extremes, zero count, unmapped register, saturation, lowered count
        stim_table.push_back(req_row(20'h00000, 6'h00, 1, '{6'd0, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'hFFFFF, 6'h3F, 1, '{6'd1, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'h55555, 6'h2A, 1, '{6'd2, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'hAAAAA, 6'h15, 1, '{6'd3, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(cfg_row(ADDR_FRAME_COUNT, 32'd0));
        stim_table.push_back(req_row(20'h12345, 6'h01, 1, '{6'd0, 1'b1, 20'h00000, 6'h00}));
        stim_table.push_back(req_row(20'h6789A, 6'h02, 1, '{6'd1, 1'b1, 20'hFFFFF, 6'h3F}));
        stim_table.push_back(cfg_row(ADDR_NO_REG, 32'd50));
        stim_table.push_back(req_row(20'h0BCDE, 6'h03, 1, '{6'd2, 1'b1, 20'h55555, 6'h2A}));
        stim_table.push_back(cfg_row(ADDR_FRAME_COUNT, 32'd6));
        stim_table.push_back(req_row(20'h11111, 6'h04, 1, '{6'd4, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'h22222, 6'h05, 1, '{6'd5, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'h33333, 6'h06, 1, '{6'd3, 1'b1, 20'hAAAAA, 6'h15}));
        stim_table.push_back(cfg_row(ADDR_FRAME_COUNT, 32'hFFFF_FFFF));
        stim_table.push_back(req_row(20'h44444, 6'h07, 1, '{6'd6, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(cfg_row(ADDR_FRAME_COUNT, 32'd1));
        stim_table.push_back(req_row(20'h00001, 6'h3E, 1, '{6'd0, 1'b1, 20'h12345, 6'h01}));
        stim_table.push_back(cfg_row(ADDR_FRAME_COUNT, 32'd64));
        stim_table.push_back(req_row(20'h80000, 6'h20, 1, '{6'd7, 1'b0, 20'h0, 6'h0}));
        stim_table.push_back(req_row(20'h7FFFF, 6'h1F, 0, '0));
        stim_table.push_back(req_row(20'hF0F0F, 6'h0F, 0, '0));
        stim_table.push_back(req_row(20'h0F0F0, 6'h30, 0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_register(ADDR_FRAME_COUNT, FRAME_COUNT_RST);

        foreach (stim_table[r]) begin
            if (stim_table[r].kind == ROW_CONFIG)
                write_register(stim_table[r].addr, stim_table[r].data);
            else
                send_request(stim_table[r].data[PAGE_W-1:0], stim_table[r].thread,
                             stim_table[r].typed, stim_table[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            frames = (phase_frames[ph] < 0) ? int'($urandom_range(0, 127))
                                            : phase_frames[ph];
            write_register(ADDR_FRAME_COUNT, 32'(frames));
            tx_gap_pct  = pct_choice[$urandom_range(0, 2)];
            rx_idle_pct = pct_choice[$urandom_range(0, 2)];
            quiet       = (ph == NUM_PHASES - 1);
            n_items = $urandom_range(75, 95);
            fork
                begin
                    for (int unsigned k = 0; k < n_items; k++)
                        send_request(PAGE_W'(pick_value(PAGE_W)),
                                     THREAD_W'(pick_value(THREAD_W)), 0, '0);
                end
                begin
                    if (ph == PRESSURE_PHASE) begin
                        repeat (10) @(posedge i_clk);
                        long_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        long_hold <= 1'b0;
                    end
                end
            join
        end

        i_in_valid <= 1'b0;
        while (grant_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
